FILE: sv/lgs_pkg.sv
// shared types and codes for the life grid generation step block
`default_nettype none

package lgs_pkg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS,
        ST_PRIME,
        ST_ROW,
        ST_FINISH
    } lgs_state_t;

    typedef logic [1:0] lgs_opcode_t;

    localparam lgs_opcode_t OP_WRITE = 2'd0;
    localparam lgs_opcode_t OP_READ  = 2'd1;
    localparam lgs_opcode_t OP_STEP  = 2'd2;

    // priming reads before the row sweep
    localparam logic [1:0] PRIME_LAST_ROW  = 2'd0;
    localparam logic [1:0] PRIME_FIRST_ROW = 2'd1;
    localparam logic [1:0] PRIME_ROW_ONE   = 2'd2;

endpackage

`default_nettype wire

FILE: sv/lgs_ram.sv
// generic simple dual port ram with registered read
`default_nettype none

module lgs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: sv/life_grid_generation_step.sv
// top level of the toroidal b3/s23 life grid with cell access and generation step
`default_nettype none

// The grid is held one row per word in a row ram (GRID_WIDTH bits wide, GRID_HEIGHT
// rows deep). After reset the block clears the ram one row a cycle and accepts no item
// until that pass is done; configuration writes are taken at any time. A cell write or
// read inside the grid reads the row, then modifies and writes it back; its result is
// loaded into the result register in the finish state once the output is free. A
// generation step, while running is enabled, does three priming row reads, then goes
// one row a cycle through a shared row update unit that counts the eight neighbors of
// every cell of the row from two row registers and the row read from the ram and writes
// the new row back, with the old first row kept aside for the wraparound at the bottom;
// then the result register is loaded likewise. The block handles one item at a time;
// the result register lets an item be accepted while the previous result still waits
// to be taken.

module life_grid_generation_step #(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire lgs_pkg::lgs_opcode_t s_opcode,
    input  wire logic [5:0]          s_cell_x,
    input  wire logic [5:0]          s_cell_y,
    input  wire logic                s_write_value,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic                     m_read_value,
    output logic                     m_op_done,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_data
);

    import lgs_pkg::*;

    localparam int AW = $clog2(GRID_HEIGHT);
    localparam int XW = $clog2(GRID_WIDTH);
    localparam logic [AW-1:0] ROW_LAST = AW'(GRID_HEIGHT - 1);
    localparam logic [AW-1:0] ROW_NEAR = AW'(GRID_HEIGHT - 2);

    lgs_state_t state_reg, state_next;

    logic                  run_enable_reg;
    logic [AW-1:0]         row_reg, row_next;
    logic [1:0]            prime_reg, prime_next;
    lgs_opcode_t           op_reg, op_next;
    logic [5:0]            x_reg, x_next;
    logic [5:0]            y_reg, y_next;
    logic                  wv_reg, wv_next;
    logic [GRID_WIDTH-1:0] above_reg, above_next;
    logic [GRID_WIDTH-1:0] mid_reg, mid_next;
    logic [GRID_WIDTH-1:0] row0_reg, row0_next;
    logic                  res_read_reg, res_read_next;
    logic                  res_done_reg, res_done_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  m_read_value_reg, m_read_value_next;
    logic                  m_op_done_reg, m_op_done_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [GRID_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [GRID_WIDTH-1:0] ram_rdata;

    logic                  s_inside;
    logic                  acc_x_inside;
    logic [XW-1:0]         col_idx;
    logic [GRID_WIDTH-1:0] below_row;
    logic [GRID_WIDTH-1:0] new_row;
    logic [GRID_WIDTH-1:0] mod_row;

    lgs_ram #(
        .WIDTH(GRID_WIDTH),
        .DEPTH(GRID_HEIGHT)
    ) u_row_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign s_ready      = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_read_value = m_read_value_reg;
    assign m_op_done    = m_op_done_reg;

    assign s_inside = (32'(s_cell_x) < 32'(GRID_WIDTH)) &&
                      (32'(s_cell_y) < 32'(GRID_HEIGHT));
    assign acc_x_inside = 1'b1;
    assign col_idx   = XW'(x_reg);
    assign below_row = (row_reg == ROW_LAST) ? row0_reg : ram_rdata;

    // row update unit: neighbor count and b3/s23 rule for every cell of one row
    always_comb begin
        int   li;
        int   ri;
        logic [3:0] n;
        for (int i = 0; i < GRID_WIDTH; i++) begin
            li = (i == 0) ? GRID_WIDTH - 1 : i - 1;
            ri = (i == GRID_WIDTH - 1) ? 0 : i + 1;
            n = 4'(above_reg[li]) + 4'(above_reg[i]) + 4'(above_reg[ri]) +
                4'(mid_reg[li]) + 4'(mid_reg[ri]) +
                4'(below_row[li]) + 4'(below_row[i]) + 4'(below_row[ri]);
            new_row[i] = (n == 4'd3) || ((n == 4'd2) && mid_reg[i]);
        end
    end

    always_comb begin
        mod_row = ram_rdata;
        mod_row[col_idx] = wv_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            row_reg        <= '0;
            prime_reg      <= '0;
            run_enable_reg <= 1'b1;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            prime_reg   <= prime_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                run_enable_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg           <= op_next;
        x_reg            <= x_next;
        y_reg            <= y_next;
        wv_reg           <= wv_next;
        above_reg        <= above_next;
        mid_reg          <= mid_next;
        row0_reg         <= row0_next;
        res_read_reg     <= res_read_next;
        res_done_reg     <= res_done_next;
        m_read_value_reg <= m_read_value_next;
        m_op_done_reg    <= m_op_done_next;
    end

    always_comb begin
        state_next        = state_reg;
        row_next          = row_reg;
        prime_next        = prime_reg;
        op_next           = op_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        wv_next           = wv_reg;
        above_next        = above_reg;
        mid_next          = mid_reg;
        row0_next         = row0_reg;
        res_read_next     = res_read_reg;
        res_done_next     = res_done_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_read_value_next = m_read_value_reg;
        m_op_done_next    = m_op_done_reg;
        ram_we            = 1'b0;
        ram_waddr         = row_reg;
        ram_wdata         = new_row;
        ram_raddr         = AW'(y_reg);

        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                if (row_reg == ROW_LAST) begin
                    row_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    row_next = row_reg + AW'(1);
                end
            end
            ST_IDLE: begin
                ram_raddr = AW'(s_cell_y);
                if (s_valid) begin
                    op_next       = s_opcode;
                    x_next        = s_cell_x;
                    y_next        = s_cell_y;
                    wv_next       = s_write_value;
                    res_read_next = 1'b0;
                    res_done_next = 1'b1;
                    if ((s_opcode == OP_WRITE || s_opcode == OP_READ) && s_inside) begin
                        state_next = ST_ACCESS;
                    end else if (s_opcode == OP_STEP && run_enable_reg) begin
                        prime_next = PRIME_LAST_ROW;
                        row_next   = '0;
                        state_next = ST_PRIME;
                    end else begin
                        res_done_next = (s_opcode == OP_WRITE || s_opcode == OP_READ ||
                                         s_opcode == OP_STEP);
                        state_next    = ST_FINISH;
                    end
                end
            end
            ST_ACCESS: begin
                ram_waddr = AW'(y_reg);
                ram_wdata = mod_row;
                ram_we    = (op_reg == OP_WRITE);
                res_read_next = (op_reg == OP_READ) && acc_x_inside && ram_rdata[col_idx];
                state_next    = ST_FINISH;
            end
            ST_PRIME: begin
                case (prime_reg)
                    PRIME_LAST_ROW: begin
                        ram_raddr  = ROW_LAST;
                        prime_next = PRIME_FIRST_ROW;
                    end
                    PRIME_FIRST_ROW: begin
                        ram_raddr  = '0;
                        above_next = ram_rdata;
                        prime_next = PRIME_ROW_ONE;
                    end
                    PRIME_ROW_ONE: begin
                        ram_raddr  = AW'(1);
                        mid_next   = ram_rdata;
                        row0_next  = ram_rdata;
                        row_next   = '0;
                        state_next = ST_ROW;
                    end
                    default: begin
                        prime_next = PRIME_LAST_ROW;
                    end
                endcase
            end
            ST_ROW: begin
                ram_we     = 1'b1;
                ram_waddr  = row_reg;
                ram_wdata  = new_row;
                ram_raddr  = (row_reg < ROW_NEAR) ? row_reg + AW'(2) : '0;
                above_next = mid_reg;
                mid_next   = ram_rdata;
                if (row_reg == ROW_LAST) begin
                    row_next   = '0;
                    state_next = ST_FINISH;
                end else begin
                    row_next = row_reg + AW'(1);
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next      = 1'b1;
                    m_read_value_next = res_read_reg;
                    m_op_done_next    = res_done_reg;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// testbench for the toroidal life grid: cell access and generation steps against a predictor
`timescale 1ns / 1ps

module tb_top;
    import lgs_pkg::*;

    localparam int GRID_W = 64;
    localparam int GRID_H = 64;
    localparam lgs_opcode_t OP_UNUSED = 2'd3;
    localparam logic [24:0] GLIDER_SHAPE = 25'h0072080;
    localparam int CFG_SETTLE = 4;
    localparam int TAIL_CYCLES = 80;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic read_value;
        logic op_done;
    } life_result_t;

    typedef struct packed {
        logic        cfg_first;
        logic        cfg_value;
        lgs_opcode_t op;
        logic [5:0]  x;
        logic [5:0]  y;
        logic        wv;
        logic        typed;
        logic        exp_read;
        logic        exp_done;
    } dir_row_t;

    localparam int DIR_ROWS = 25;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{1'b0, 1'b0, OP_READ,   6'd0,  6'd0,  1'b0, 1'b1, 1'b0, 1'b1},
        '{1'b0, 1'b0, OP_READ,   6'd63, 6'd63, 1'b1, 1'b1, 1'b0, 1'b1},
        '{1'b0, 1'b0, OP_UNUSED, 6'd63, 6'd63, 1'b1, 1'b1, 1'b0, 1'b0},
        '{1'b0, 1'b0, OP_WRITE,  6'd63, 6'd63, 1'b1, 1'b1, 1'b0, 1'b1},
        '{1'b0, 1'b0, OP_READ,   6'd63, 6'd63, 1'b0, 1'b1, 1'b1, 1'b1},
        '{1'b0, 1'b0, OP_WRITE,  6'd63, 6'd63, 1'b0, 1'b1, 1'b0, 1'b1},
        '{1'b0, 1'b0, OP_READ,   6'd63, 6'd63, 1'b1, 1'b1, 1'b0, 1'b1},
        '{1'b0, 1'b0, OP_WRITE,  6'd63, 6'd0,  1'b1, 1'b1, 1'b0, 1'b1},
        '{1'b0, 1'b0, OP_WRITE,  6'd0,  6'd0,  1'b1, 1'b1, 1'b0, 1'b1},
        '{1'b0, 1'b0, OP_WRITE,  6'd1,  6'd0,  1'b1, 1'b1, 1'b0, 1'b1},
        '{1'b0, 1'b0, OP_STEP,   6'd63, 6'd63, 1'b1, 1'b1, 1'b0, 1'b1},
        '{1'b0, 1'b0, OP_READ,   6'd0,  6'd63, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b0, OP_READ,   6'd0,  6'd1,  1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b0, OP_READ,   6'd63, 6'd0,  1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b1, 1'b0, OP_STEP,   6'd0,  6'd0,  1'b0, 1'b1, 1'b0, 1'b1},
        '{1'b0, 1'b0, OP_READ,   6'd0,  6'd63, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b0, OP_READ,   6'd63, 6'd0,  1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b1, 1'b1, OP_STEP,   6'd21, 6'd42, 1'b1, 1'b1, 1'b0, 1'b1},
        '{1'b0, 1'b0, OP_READ,   6'd63, 6'd0,  1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b0, OP_READ,   6'd0,  6'd63, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b0, OP_UNUSED, 6'd0,  6'd0,  1'b0, 1'b1, 1'b0, 1'b0},
        '{1'b0, 1'b0, OP_WRITE,  6'd0,  6'd0,  1'b0, 1'b1, 1'b0, 1'b1},
        '{1'b0, 1'b0, OP_STEP,   6'd0,  6'd0,  1'b0, 1'b1, 1'b0, 1'b1},
        '{1'b0, 1'b0, OP_READ,   6'd63, 6'd0,  1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b0, OP_READ,   6'd1,  6'd0,  1'b0, 1'b0, 1'b0, 1'b0}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    lgs_opcode_t s_opcode = OP_READ;
    logic [5:0]  s_cell_x = '0;
    logic [5:0]  s_cell_y = '0;
    logic        s_write_value = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_read_value;
    logic        m_op_done;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;

    logic [GRID_W-1:0] life_rows [GRID_H];
    logic              run_enable_model;
    life_result_t      pending_results [$];

    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    int          hold_request = 0;
    int          hold_left = 0;
    int          items_sent = 0;
    int          steps_sent = 0;
    int          halted_steps = 0;
    int          cfg_writes = 0;
    int          results_checked = 0;
    int          mismatches = 0;
    int          input_stall_cycles = 0;

    life_grid_generation_step #(
        .GRID_WIDTH(GRID_W),
        .GRID_HEIGHT(GRID_H)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_opcode(s_opcode),
        .s_cell_x(s_cell_x),
        .s_cell_y(s_cell_y),
        .s_write_value(s_write_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_read_value(m_read_value),
        .m_op_done(m_op_done),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        #8_000_000;
        $display("status: fail");
        $finish;
    end

    // b3/s23 over the old grid, wrapping at every edge
    function automatic void evolve_grid();
        logic [GRID_W-1:0] nxt [GRID_H];
        int xl, xr, yu, yd, n;
        for (int y = 0; y < GRID_H; y++) begin
            for (int x = 0; x < GRID_W; x++) begin
                xl = (x == 0) ? GRID_W - 1 : x - 1;
                xr = (x == GRID_W - 1) ? 0 : x + 1;
                yu = (y == 0) ? GRID_H - 1 : y - 1;
                yd = (y == GRID_H - 1) ? 0 : y + 1;
                n = int'(life_rows[yu][xl]) + int'(life_rows[yu][x]) + int'(life_rows[yu][xr])
                  + int'(life_rows[y][xl]) + int'(life_rows[y][xr])
                  + int'(life_rows[yd][xl]) + int'(life_rows[yd][x]) + int'(life_rows[yd][xr]);
                nxt[y][x] = (n == 3) || (n == 2 && life_rows[y][x]);
            end
        end
        life_rows = nxt;
    endfunction

    function automatic life_result_t life_predict(lgs_opcode_t op, logic [5:0] cx,
                                                  logic [5:0] cy, logic wv);
        life_result_t r;
        r.read_value = 1'b0;
        r.op_done = 1'b1;
        case (op)
            OP_WRITE: begin
                if (int'(cx) < GRID_W && int'(cy) < GRID_H) life_rows[cy][cx] = wv;
            end
            OP_READ: begin
                if (int'(cx) < GRID_W && int'(cy) < GRID_H) r.read_value = life_rows[cy][cx];
            end
            OP_STEP: begin
                if (run_enable_model) evolve_grid();
            end
            default: begin
                r.op_done = 1'b0;
            end
        endcase
        return r;
    endfunction

    task automatic send_item(input lgs_opcode_t op, input logic [5:0] cx, input logic [5:0] cy,
                             input logic wv, input logic typed, input life_result_t typed_res);
        life_result_t res;
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_cell_x <= cx;
        s_cell_y <= cy;
        s_write_value <= wv;
        do @(posedge aclk); while (!s_ready);
        if (op == OP_STEP) begin
            steps_sent++;
            if (!run_enable_model) halted_steps++;
        end
        res = life_predict(op, cx, cy, wv);
        pending_results.push_back(typed ? typed_res : res);
        items_sent++;
    endtask

    task automatic wait_results_drained(input int settle);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_run_enable(input logic value);
        wait_results_drained(CFG_SETTLE);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        run_enable_model = value;
        cfg_writes++;
    endtask

    // mostly seeded patches or gliders followed by steps and reads around them, plus loose items
    task automatic run_phase(input int n_items, input int unsigned gap, input int unsigned stall,
                             input logic run_en, input int long_hold);
        int          start_count;
        int          w, h;
        logic        glider;
        logic        v;
        logic [5:0]  ox, oy;
        int unsigned pick;
        lgs_opcode_t op;
        write_run_enable(run_en);
        gap_pct = gap;
        stall_pct = stall;
        hold_request = long_hold;
        start_count = items_sent;
        while (items_sent - start_count < n_items) begin
            if ($urandom_range(3) == 0) begin
                ox = 6'($urandom_range(63));
                oy = 6'($urandom_range(63));
                glider = ($urandom_range(2) == 0);
                w = glider ? 5 : int'($urandom_range(3, 5));
                h = glider ? 5 : int'($urandom_range(3, 5));
                for (int dy = 0; dy < h; dy++) begin
                    for (int dx = 0; dx < w; dx++) begin
                        v = glider ? GLIDER_SHAPE[dy * 5 + dx] : ($urandom_range(99) < 40);
                        send_item(OP_WRITE, 6'(int'(ox) + dx), 6'(int'(oy) + dy), v, 1'b0, '0);
                    end
                end
                repeat ($urandom_range(1, 4)) begin
                    send_item(OP_STEP, 6'($urandom_range(63)), 6'($urandom_range(63)),
                              1'($urandom_range(1)), 1'b0, '0);
                end
                repeat ($urandom_range(4, 8)) begin
                    send_item(OP_READ, 6'(int'(ox) + int'($urandom_range(w + 1)) - 1),
                              6'(int'(oy) + int'($urandom_range(h + 1)) - 1),
                              1'($urandom_range(1)), 1'b0, '0);
                end
            end else begin
                pick = $urandom_range(15);
                op = (pick < 6) ? OP_WRITE : (pick < 12) ? OP_READ :
                     (pick < 14) ? OP_STEP : OP_UNUSED;
                send_item(op, 6'($urandom_range(63)), 6'($urandom_range(63)),
                          1'($urandom_range(1)), 1'b0, '0);
            end
        end
    endtask

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        life_result_t want;
        if (aresetn && s_valid && !s_ready) input_stall_cycles++;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected result item: read_value=%0b op_done=%0b",
                             m_read_value, m_op_done);
                end
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (m_read_value !== want.read_value || m_op_done !== want.op_done) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("result %0d: read_value exp %0b got %0b, op_done exp %0b got %0b",
                                 results_checked, want.read_value, m_read_value,
                                 want.op_done, m_op_done);
                    end
                end
            end
        end
    end

    initial begin
        life_result_t typed_res;
        for (int r = 0; r < GRID_H; r++) life_rows[r] = '0;
        run_enable_model = 1'b1;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (DIRECTED[i].cfg_first) write_run_enable(DIRECTED[i].cfg_value);
            typed_res.read_value = DIRECTED[i].exp_read;
            typed_res.op_done = DIRECTED[i].exp_done;
            send_item(DIRECTED[i].op, DIRECTED[i].x, DIRECTED[i].y, DIRECTED[i].wv,
                      DIRECTED[i].typed, typed_res);
        end

        run_phase(230, 0, 0, 1'b1, 0);
        run_phase(230, 52, 0, 1'b1, 0);
        run_phase(200, 0, 52, 1'b0, 0);
        run_phase(230, 9, 9, 1'b1, 0);
        run_phase(220, 0, 0, 1'b1, 400);
        run_phase(220, 52, 52, 1'b1, 0);

        wait_results_drained(TAIL_CYCLES);

        $display("covered %0d items, %0d generation steps (%0d while halted), %0d config writes",
                 items_sent, steps_sent, halted_steps, cfg_writes);
        $display("checked %0d results, %0d mismatches, input held off for %0d cycles",
                 results_checked, mismatches, input_stall_cycles);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
